>>> sv/i2cmra_pkg.sv
package i2cmra_pkg;

    localparam int unsigned TDATA_IN_W  = 40;
    localparam int unsigned TDATA_OUT_W = 16;
    localparam int unsigned FUNC_W      = 2;
    localparam int unsigned COUNT_W     = 9;
    localparam int unsigned TIMEOUT_W   = 16;

    localparam logic [COUNT_W-1:0]   MAX_READ_BYTES = 9'd256;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET  = 16'd1000;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [6:0]         dev_addr;
        logic [7:0]         sub_addr;
        logic [7:0]         wr_data;
        logic [COUNT_W-1:0] rd_count;
        logic               sda_in;
    } item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic [7:0] rd_byte;
        logic       rd_valid;
        logic       rd_last;
        logic       done_res;
        logic       error;
        logic       busy_res;
    } result_t;

endpackage

>>> sv/i2c_master_register_access.sv
// An accepted input item passes the input register, then the result register, to
// the master side. One item per cycle while the master side accepts results; the phase
// state machine updates once per item in a single pass between those two registers.
// Reset (rst_n, async, active low): bus released (SCL = SDA = 1), idle, both stages
// empty, ACK timeout back to 1000 ticks.
module i2c_master_register_access
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [i2cmra_pkg::TIMEOUT_W-1:0]      cfg_wr_data,   // ack_timeout_ticks
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // dev_addr[6:0], sub_addr[14:7], wr_data[22:15], rd_count[31:23], sda_in[32], zero
    input  logic [i2cmra_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
    input  logic [i2cmra_pkg::FUNC_W-1:0]         s_axis_tuser,  // func[1:0]
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // scl_out[0], sda_out[1], rd_byte[9:2], done_res[10], error[11], busy_res[12], zero
    output logic [i2cmra_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    output logic                                  m_axis_tuser,  // rd_valid
    output logic                                  m_axis_tlast   // rd_last
);
    import i2cmra_pkg::*;

    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    advance;
    result_t result;
    result_t out_result;

    always_comb
    begin
        in_item.func     = s_axis_tuser;
        in_item.dev_addr = s_axis_tdata[6:0];
        in_item.sub_addr = s_axis_tdata[14:7];
        in_item.wr_data  = s_axis_tdata[22:15];
        in_item.rd_count = s_axis_tdata[31:23];
        in_item.sda_in   = s_axis_tdata[32];
    end

    i2cmra_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    i2cmra_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .advance     (advance),
        .item        (item),
        .result      (result)
    );

    i2cmra_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .result     (result),
        .advance    (advance),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (out_result)
    );

    assign m_axis_tdata = {3'b000, out_result.busy_res, out_result.error,
                           out_result.done_res, out_result.rd_byte,
                           out_result.sda_out, out_result.scl_out};
    assign m_axis_tuser = out_result.rd_valid;
    assign m_axis_tlast = out_result.rd_last;

endmodule

>>> sv/i2cmra_in_stage.sv
module i2cmra_in_stage
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  i2cmra_pkg::item_t   in_item,
    input  logic                advance,
    output logic                item_valid,
    output i2cmra_pkg::item_t   item
);
    import i2cmra_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // the register frees up in the same cycle its item moves on
    assign in_ready   = !valid_reg || advance;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

>>> sv/i2cmra_core.sv
module i2cmra_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [i2cmra_pkg::TIMEOUT_W-1:0]     cfg_wr_data,
    input  logic                                 advance,
    input  i2cmra_pkg::item_t                    item,
    output i2cmra_pkg::result_t                  result
);
    import i2cmra_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2,
        PH_TX0, PH_TX1, PH_TX2,
        PH_AK0, PH_AK1, PH_AK2,
        PH_RX0, PH_RX1, PH_RX2,
        PH_MA0, PH_MA1, PH_MA2,
        PH_SP0, PH_SP1, PH_SP2
    } phase_t;

    // byte sequence: address, subaddress, data / stop, read address
    typedef enum logic [1:0] {
        SEQ_ADDR, SEQ_SUB, SEQ_DATA, SEQ_RADDR
    } seq_t;

    phase_t               phase_reg, phase_next;
    seq_t                 seq_reg, seq_next;
    logic [2:0]           bit_reg, bit_next;
    logic [7:0]           shift_reg, shift_next;
    logic [COUNT_W-1:0]   left_reg, left_next;
    logic [TIMEOUT_W-1:0] wait_reg, wait_next;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [6:0]           addr_reg, addr_next;
    logic [7:0]           sub_reg, sub_next;
    logic [7:0]           data_reg, data_next;
    logic                 read_reg, read_next;
    logic                 err_reg, err_next;
    logic                 scl_reg, scl_next;
    logic                 sda_reg, sda_next;

    logic [TIMEOUT_W-1:0] limit;
    logic [TIMEOUT_W-1:0] wait_inc;
    logic [COUNT_W-1:0]   count_sat;
    logic [COUNT_W-1:0]   left_dec;

    assign limit    = (timeout_reg == '0) ? TIMEOUT_W'(1) : timeout_reg;
    assign wait_inc = wait_reg + TIMEOUT_W'(1);
    assign left_dec = (left_reg != '0) ? (left_reg - COUNT_W'(1)) : left_reg;

    always_comb
    begin
        if (item.rd_count == '0)
            count_sat = COUNT_W'(1);
        else if (item.rd_count > MAX_READ_BYTES)
            count_sat = MAX_READ_BYTES;
        else
            count_sat = item.rd_count;
    end

    always_comb
    begin
        phase_next = phase_reg;
        seq_next   = seq_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        left_next  = left_reg;
        wait_next  = wait_reg;
        addr_next  = addr_reg;
        sub_next   = sub_reg;
        data_next  = data_reg;
        read_next  = read_reg;
        err_next   = err_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        result     = '0;

        if (item.func != FUNC_TICK)
        begin
            if (phase_reg == PH_IDLE && (item.func == FUNC_WRITE || item.func == FUNC_READ))
            begin
                addr_next  = item.dev_addr;
                sub_next   = item.sub_addr;
                data_next  = item.wr_data;
                read_next  = (item.func == FUNC_READ);
                left_next  = count_sat;
                seq_next   = SEQ_ADDR;
                err_next   = 1'b0;
                wait_next  = '0;
                bit_next   = '0;
                shift_next = '0;
                phase_next = PH_ST0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                PH_ST0:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    phase_next = PH_ST1;
                end
                PH_ST1:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                    phase_next = PH_ST2;
                end
                PH_ST2:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                    shift_next = {addr_reg, seq_reg == SEQ_RADDR};
                    bit_next = '0;
                    phase_next = PH_TX0;
                end
                PH_TX0, PH_TX1, PH_TX2:
                begin
                    sda_next = shift_reg[~bit_reg];
                    scl_next = (phase_reg == PH_TX1);
                    if (phase_reg == PH_TX0)
                        phase_next = PH_TX1;
                    else if (phase_reg == PH_TX1)
                        phase_next = PH_TX2;
                    else if (bit_reg == 3'd7)
                    begin
                        wait_next  = '0;
                        phase_next = PH_AK0;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_TX0;
                    end
                end
                PH_AK0:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    phase_next = PH_AK1;
                end
                PH_AK1:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    if (!item.sda_in)
                        phase_next = PH_AK2;
                    else
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= limit)
                        begin
                            err_next   = 1'b1;
                            phase_next = PH_SP0;
                        end
                    end
                end
                PH_AK2:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    unique case (seq_reg)
                        SEQ_ADDR:
                        begin
                            seq_next   = SEQ_SUB;
                            shift_next = sub_reg;
                            bit_next   = '0;
                            phase_next = PH_TX0;
                        end
                        SEQ_SUB:
                        begin
                            seq_next = SEQ_DATA;
                            if (read_reg)
                                phase_next = PH_SP0;
                            else
                            begin
                                shift_next = data_reg;
                                bit_next   = '0;
                                phase_next = PH_TX0;
                            end
                        end
                        SEQ_RADDR:
                        begin
                            bit_next   = '0;
                            shift_next = '0;
                            phase_next = PH_RX0;
                        end
                        default:
                        begin
                            phase_next = PH_SP0;
                        end
                    endcase
                end
                PH_RX0:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    phase_next = PH_RX1;
                end
                PH_RX1:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    shift_next = {shift_reg[6:0], item.sda_in};
                    phase_next = PH_RX2;
                end
                PH_RX2:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                    if (bit_reg == 3'd7)
                    begin
                        result.rd_valid = 1'b1;
                        result.rd_byte  = shift_reg;
                        result.rd_last  = (left_reg <= COUNT_W'(1));
                        phase_next      = PH_MA0;
                    end
                    else
                    begin
                        bit_next   = bit_reg + 3'd1;
                        phase_next = PH_RX0;
                    end
                end
                PH_MA0, PH_MA1, PH_MA2:
                begin
                    // NACK on the final byte
                    sda_next = (left_reg <= COUNT_W'(1));
                    scl_next = (phase_reg == PH_MA1);
                    if (phase_reg == PH_MA0)
                        phase_next = PH_MA1;
                    else if (phase_reg == PH_MA1)
                        phase_next = PH_MA2;
                    else
                    begin
                        left_next = left_dec;
                        if (left_dec == '0)
                            phase_next = PH_SP0;
                        else
                        begin
                            bit_next   = '0;
                            shift_next = '0;
                            phase_next = PH_RX0;
                        end
                    end
                end
                PH_SP0:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                    phase_next = PH_SP1;
                end
                PH_SP1:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b0;
                    phase_next = PH_SP2;
                end
                PH_SP2:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    // a read restarts with the read address after the setup stop
                    if (!err_reg && read_reg && seq_reg == SEQ_DATA)
                    begin
                        seq_next   = SEQ_RADDR;
                        phase_next = PH_ST0;
                    end
                    else
                    begin
                        result.done_res = 1'b1;
                        result.error    = err_reg;
                        err_next        = 1'b0;
                        phase_next      = PH_IDLE;
                    end
                end
                default:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result.scl_out  = scl_next;
        result.sda_out  = sda_next;
        result.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            phase_reg   <= PH_IDLE;
            seq_reg     <= SEQ_ADDR;
            bit_reg     <= '0;
            shift_reg   <= '0;
            left_reg    <= '0;
            wait_reg    <= '0;
            addr_reg    <= '0;
            sub_reg     <= '0;
            data_reg    <= '0;
            read_reg    <= 1'b0;
            err_reg     <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                timeout_reg <= cfg_wr_data;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
                seq_reg   <= seq_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                left_reg  <= left_next;
                wait_reg  <= wait_next;
                addr_reg  <= addr_next;
                sub_reg   <= sub_next;
                data_reg  <= data_next;
                read_reg  <= read_next;
                err_reg   <= err_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
            end
        end
    end

endmodule

>>> sv/i2cmra_out_stage.sv
module i2cmra_out_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    input  i2cmra_pkg::result_t   result,
    output logic                  advance,
    output logic                  out_valid,
    input  logic                  out_ready,
    output i2cmra_pkg::result_t   out_result
);
    import i2cmra_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance    = item_valid && (!valid_reg || out_ready);
    assign valid_next = advance ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule
